/* hdl/mwdw_pkg.sv */
package mwdw_pkg;

    localparam int LIMB_W = 64;
    localparam int WIDE_W = 2 * LIMB_W;
    localparam int CNT_W  = $clog2(WIDE_W);

    localparam logic [CNT_W-1:0] NARROW_LAST_STEP = CNT_W'(LIMB_W - 1);
    localparam logic [CNT_W-1:0] WIDE_LAST_STEP   = CNT_W'(WIDE_W - 1);

    typedef logic [LIMB_W-1:0] limb_t;

    typedef struct packed {
        limb_t quotient;
        limb_t remainder;
        logic  last;
        logic  err;
    } mwdw_res_t;

endpackage

/* hdl/mwdw_step.sv */
module mwdw_step
    import mwdw_pkg::*;
(
    input  limb_t rem_in,
    input  logic  bit_in,
    input  limb_t divisor,
    output limb_t rem_out,
    output logic  q_bit
);

    logic  top;
    limb_t shifted;

    assign top     = rem_in[LIMB_W-1];
    assign shifted = {rem_in[LIMB_W-2:0], bit_in};
    assign q_bit   = top | (shifted >= divisor);
    assign rem_out = q_bit ? (shifted - divisor) : shifted;

endmodule

/* hdl/mwdw_core.sv */
module mwdw_core
    import mwdw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  limb_t     hi,
    input  limb_t     lo,
    input  logic      last,
    input  limb_t     divisor,
    input  logic      res_ready,
    output logic      busy,
    output logic      res_valid,
    output mwdw_res_t res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    limb_t             rem_reg, rem_next;
    logic [WIDE_W-1:0] dv_reg, dv_next;
    logic              last_reg, last_next;
    logic              err_reg, err_next;

    limb_t step_rem;
    logic  step_q;

    mwdw_step u_step (
        .rem_in  (rem_reg),
        .bit_in  (dv_reg[WIDE_W-1]),
        .divisor (divisor),
        .rem_out (step_rem),
        .q_bit   (step_q)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dv_next    = dv_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    last_next = last;
                    err_next  = (divisor == '0);
                    if (divisor == '0)
                    begin
                        rem_next   = '0;
                        dv_next    = '0;
                        state_next = ST_DONE;
                    end
                    else if (hi < divisor)
                    begin
                        rem_next   = hi;
                        dv_next    = {lo, {LIMB_W{1'b0}}};
                        cnt_next   = NARROW_LAST_STEP;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        rem_next   = '0;
                        dv_next    = {hi, lo};
                        cnt_next   = WIDE_LAST_STEP;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                rem_next = step_rem;
                dv_next  = {dv_reg[WIDE_W-2:0], step_q};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dv_reg   <= dv_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign res_valid     = (state_reg == ST_DONE);
    assign res.quotient  = dv_reg[LIMB_W-1:0];
    assign res.remainder = rem_reg;
    assign res.last      = last_reg;
    assign res.err       = err_reg;

endmodule

/* hdl/multiword_divide_by_word_top.sv */
// Divides a number of 64-bit limbs, most significant first, by the 64-bit divisor in the
// configuration register (reset value 1), giving one quotient limb and the running remainder
// per limb; the beat flagged last_limb carries the final remainder and clears the running
// remainder for the next number. A zero divisor raises divide_error with zero quotient and
// remainder. One shared shift-compare-subtract unit yields one quotient bit per cycle, so a
// limb takes 64 steps plus load and hand-off; the steps run over the full double-width value
// when the running remainder is not below the divisor (divisor rewritten mid-number), and
// a zero divisor skips them. in_stall stays high from load until hand-off; a finished beat
// waits in the output register while the next limb is taken.
module multiword_divide_by_word_top
    import mwdw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_write_enable,
    input  limb_t cfg_write_data,
    input  logic  in_valid,
    output logic  in_stall,
    input  limb_t limb,
    input  logic  last_limb,
    output logic  out_valid,
    input  logic  out_stall,
    output limb_t quotient_limb,
    output limb_t remainder,
    output logic  is_last,
    output logic  divide_error
);

    limb_t     divisor_reg;
    limb_t     run_rem_reg, run_rem_next;
    logic      out_valid_reg, out_valid_next;
    mwdw_res_t out_reg;

    logic      core_busy;
    logic      res_valid;
    logic      res_ready;
    logic      in_accept;
    logic      res_take;
    mwdw_res_t res;

    assign in_accept = in_valid & ~core_busy;
    assign res_ready = ~out_valid_reg | ~out_stall;
    assign res_take  = res_valid & res_ready;

    mwdw_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .hi        (run_rem_reg),
        .lo        (limb),
        .last      (last_limb),
        .divisor   (divisor_reg),
        .res_ready (res_ready),
        .busy      (core_busy),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        run_rem_next   = run_rem_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_valid_next = 1'b1;
            run_rem_next   = res.last ? '0 : res.remainder;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg   <= limb_t'(1);
            run_rem_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                divisor_reg <= cfg_write_data;
            end
            run_rem_reg   <= run_rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the beat while stalled
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign in_stall      = core_busy;
    assign out_valid     = out_valid_reg;
    assign quotient_limb = out_reg.quotient;
    assign remainder     = out_reg.remainder;
    assign is_last       = out_reg.last;
    assign divide_error  = out_reg.err;

endmodule

/* verif/divide_checker.sv */
module divide_checker
    import mwdw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_write_enable,
    input  limb_t cfg_write_data,
    input  logic  in_valid,
    input  logic  in_stall,
    input  limb_t limb,
    input  logic  last_limb,
    input  logic  out_valid,
    input  logic  out_stall,
    input  limb_t quotient_limb,
    input  limb_t remainder,
    input  logic  is_last,
    input  logic  divide_error,
    output int    mismatches,
    output int    outstanding
);

    limb_t     divisor_now;
    limb_t     carried_rem;
    int        fail_count;
    mwdw_res_t due;
    mwdw_res_t pending_quotients[$];

    function automatic mwdw_res_t divide_limb(limb_t value, logic lst);
        mwdw_res_t             res;
        logic [WIDE_W-1:0]     wide;
        logic [WIDE_W-1:0]     wide_div;
        res      = '0;
        res.last = lst;
        if (divisor_now == '0)
        begin
            res.err     = 1'b1;
            carried_rem = '0;
        end
        else
        begin
            wide          = {carried_rem, value};
            wide_div      = {{LIMB_W{1'b0}}, divisor_now};
            res.quotient  = limb_t'(wide / wide_div);
            res.remainder = limb_t'(wide % wide_div);
            carried_rem   = res.remainder;
        end
        if (lst)
            carried_rem = '0;
        return res;
    endfunction

    task automatic report_mismatch(string what, limb_t got, limb_t want);
        if (fail_count < 40)
            $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_now = limb_t'(1);
            carried_rem = '0;
            fail_count  = 0;
            pending_quotients.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_quotients.size() == 0)
                    report_mismatch("unexpected beat, quotient_limb", quotient_limb, '0);
                else
                begin
                    due = pending_quotients.pop_front();
                    if (quotient_limb !== due.quotient)
                        report_mismatch("quotient_limb", quotient_limb, due.quotient);
                    if (remainder !== due.remainder)
                        report_mismatch("remainder", remainder, due.remainder);
                    if (is_last !== due.last)
                        report_mismatch("is_last", limb_t'(is_last), limb_t'(due.last));
                    if (divide_error !== due.err)
                        report_mismatch("divide_error", limb_t'(divide_error),
                                        limb_t'(due.err));
                end
            end
            if (in_valid && !in_stall)
                pending_quotients.push_back(divide_limb(limb, last_limb));
            if (cfg_write_enable)
                divisor_now = cfg_write_data;
            mismatches  <= fail_count;
            outstanding <= pending_quotients.size();
        end
    end

endmodule

/* verif/tb.sv */
module tb;
    import mwdw_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASES       = 15;
    localparam int PHASE_BEATS  = 50;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_e;

    logic  clk              = 1'b0;
    logic  rst_n            = 1'b0;
    logic  cfg_write_enable = 1'b0;
    limb_t cfg_write_data   = '0;
    logic  in_valid         = 1'b0;
    limb_t limb             = '0;
    logic  last_limb        = 1'b0;
    logic  out_stall        = 1'b0;
    logic  in_stall;
    logic  out_valid;
    limb_t quotient_limb;
    limb_t remainder;
    logic  is_last;
    logic  divide_error;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          number_left = 0;
    stall_mode_e stall_mode  = STALL_NONE;
    int          mode_left   = 0;
    int          hold_left   = 0;

    multiword_divide_by_word_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .limb             (limb),
        .last_limb        (last_limb),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .quotient_limb    (quotient_limb),
        .remainder        (remainder),
        .is_last          (is_last),
        .divide_error     (divide_error)
    );

    divide_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .limb             (limb),
        .last_limb        (last_limb),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .quotient_limb    (quotient_limb),
        .remainder        (remainder),
        .is_last          (is_last),
        .divide_error     (divide_error),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver back-pressure: the stall mode is picked at random and held for a random span
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:  out_stall = 1'b0;
            STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall = 1'($urandom_range(0, 1));
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_left = $urandom_range(1, 120);
                    out_stall = ~out_stall;
                end
                hold_left--;
            end
        endcase
    end

    task automatic send_beat(limb_t value, logic lst);
        int pause;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            pause      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            if (pause != 0)
            begin
                in_valid = 1'b0;
                repeat (pause) @(negedge clk);
            end
        end
        burst_left--;
        in_valid  = 1'b1;
        limb      = value;
        last_limb = lst;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop valid and wait for every beat to come back before touching the divisor
    task automatic write_divisor(limb_t value);
        @(negedge clk);
        in_valid   = 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write_enable = 1'b1;
        cfg_write_data   = value;
        @(negedge clk);
        cfg_write_enable = 1'b0;
    endtask

    function automatic limb_t pick_limb();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return limb_t'($urandom_range(0, 255));
            3:       return {1'b1, 31'($urandom), 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic limb_t pick_divisor();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return limb_t'(1);
            2:       return '1;
            3:       return limb_t'(1) << $urandom_range(0, 63);
            4:       return limb_t'($urandom_range(2, 16));
            5:       return {32'b0, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        send_beat('0, 1'b0);
        send_beat('1, 1'b0);
        send_beat('1, 1'b1);

        write_divisor('1);
        send_beat('1, 1'b0);
        send_beat('1, 1'b0);
        send_beat(64'h0123_4567_89ab_cdef, 1'b1);

        write_divisor(64'h8000_0000_0000_0000);
        send_beat('1, 1'b0);
        send_beat(64'h7fff_ffff_ffff_ffff, 1'b1);

        write_divisor(limb_t'(3));
        send_beat(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        send_beat(64'h5555_5555_5555_5555, 1'b0);
        send_beat(limb_t'(1), 1'b1);

        // shrink the divisor under a large carried remainder
        write_divisor('1);
        send_beat(64'hffff_ffff_ffff_fffe, 1'b0);
        write_divisor(limb_t'(2));
        send_beat('1, 1'b1);

        write_divisor(limb_t'(7));
        send_beat('1, 1'b0);
        write_divisor(limb_t'(1));
        send_beat(limb_t'(5), 1'b1);

        write_divisor('0);
        send_beat('1, 1'b0);
        send_beat(64'h1234, 1'b1);
        send_beat('1, 1'b0);
        write_divisor(limb_t'(5));
        send_beat(limb_t'(9), 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_divisor(pick_divisor());
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (number_left == 0)
                    number_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                              : $urandom_range(1, 8);
                number_left--;
                send_beat(pick_limb(), number_left == 0);
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
